// ----- hw/rtl/kbt_pkg.sv -----
// Shared types and constants of the key binding table.
// Used by kbt_bitmap, kbt_cell and key_binding_table; depends on nothing.
`default_nettype none

package kbt_pkg;

   // Field widths of the transaction ports
   localparam int KEY_CODE_BITS     = 7;
   localparam int MOD_BITS          = 5;
   localparam int KEY_BITS          = KEY_CODE_BITS + MOD_BITS;
   localparam int HANDLE_FIELD_BITS = 16;
   localparam int STATUS_BITS       = 2;

   // Presence bitmap geometry: 4096 bits as 128 rows of 32 bits
   localparam int MAP_ROW_BITS  = 32;
   localparam int MAP_SEL_BITS  = 5;
   localparam int MAP_ROWS      = (1 << KEY_BITS) / MAP_ROW_BITS;
   localparam int MAP_ADDR_BITS = KEY_BITS - MAP_SEL_BITS;

   // Operation codes
   localparam logic OP_BIND   = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // Status codes
   localparam logic [STATUS_BITS-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_MISS = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL = 2'd2;

   // Probe that walks the cell chain, one cell per cycle
   typedef struct packed {
      logic                active;  // probe present at this stage
      logic                op;      // OP_BIND or OP_LOOKUP
      logic [KEY_BITS-1:0] key;     // modifiers * 128 + key code
      logic                screen;  // key bit set in presence bitmap
      logic                done;    // matched or filled upstream
      logic                filled;  // a free slot took this key
   } kbt_probe_type;

   // Write port of the presence bitmap
   typedef struct packed {
      logic                     en;
      logic [MAP_ADDR_BITS-1:0] row;
      logic [MAP_ROW_BITS-1:0]  data;
   } kbt_map_wr_type;

endpackage

`default_nettype wire

// ----- hw/rtl/kbt_bitmap.sv -----
// Presence bitmap: 128 x 32 memory with a clearing pass after reset.
// Depends on kbt_pkg.
`default_nettype none

module kbt_bitmap (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic [kbt_pkg::MAP_ADDR_BITS-1:0]       rd_row,
   output logic [kbt_pkg::MAP_ROW_BITS-1:0]        rd_data,
   input  kbt_pkg::kbt_map_wr_type                 wr,
   output logic                                    busy
);
   import kbt_pkg::*;

   logic [MAP_ROW_BITS-1:0]  mem [MAP_ROWS];
   logic [MAP_ROW_BITS-1:0]  rd_data_ff;
   logic [MAP_ADDR_BITS-1:0] clr_row_ff;
   logic [MAP_ADDR_BITS-1:0] clr_row_in;
   logic                     busy_ff;
   logic                     busy_in;

   // Advance the clearing pass one row a cycle
   always_comb begin
      clr_row_in = clr_row_ff;
      busy_in    = busy_ff;
      if (busy_ff) begin
         clr_row_in = clr_row_ff + 1'b1;
         if (clr_row_ff == MAP_ADDR_BITS'(MAP_ROWS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         clr_row_ff <= '0;
      end else begin
         busy_ff    <= busy_in;
         clr_row_ff <= clr_row_in;
      end
   end

   // Write zeros while clearing, else the requested row
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_row_ff] <= '0;
      end else if (wr.en) begin
         mem[wr.row] <= wr.data;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_row];
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/kbt_cell.sv -----
// One slot of the binding table: holds valid, key and handle, and passes
// the probe to its neighbor each cycle. Depends on kbt_pkg.
`default_nettype none

module kbt_cell #(
   parameter int HANDLE_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  kbt_pkg::kbt_probe_type   probe_in,
   input  logic [HANDLE_BITS-1:0]   handle_in,
   output kbt_pkg::kbt_probe_type   probe_out,
   output logic [HANDLE_BITS-1:0]   handle_out
);
   import kbt_pkg::*;

   logic                   valid_ff;
   logic [KEY_BITS-1:0]    key_ff;
   logic [HANDLE_BITS-1:0] handle_ff;
   kbt_probe_type          probe_ff;
   kbt_probe_type          probe_in_next;
   logic [HANDLE_BITS-1:0] lane_ff;
   logic [HANDLE_BITS-1:0] lane_in;
   logic                   hit;
   logic                   fill;

   // Match a bound key, or take the probe into this slot if free.
   // Slots fill from the low end and are never freed, so no match can sit
   // past the first free slot.
   assign hit  = probe_in.active && probe_in.screen && !probe_in.done &&
                 valid_ff && (key_ff == probe_in.key);
   assign fill = probe_in.active && !probe_in.done &&
                 (probe_in.op == OP_BIND) && !valid_ff;

   always_comb begin
      probe_in_next        = probe_in;
      probe_in_next.done   = probe_in.done | hit | fill;
      probe_in_next.filled = probe_in.filled | fill;
      lane_in              = handle_in;
      if (hit && (probe_in.op == OP_LOOKUP)) begin
         lane_in = handle_ff;
      end
   end

   // Slot state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (fill) begin
         valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (fill) begin
         key_ff <= probe_in.key;
      end
      if (fill || (hit && (probe_in.op == OP_BIND))) begin
         handle_ff <= handle_in;
      end
   end

   // Hand the probe to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
      end else begin
         probe_ff <= probe_in_next;
      end
   end

   always_ff @(posedge clock) begin
      lane_ff <= lane_in;
   end

   assign probe_out  = probe_ff;
   assign handle_out = lane_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/key_binding_table.sv -----
// Key binding table: binds 12-bit keys (modifiers * 128 + key code) to
// macro handles.
//
// Channels: req_ carries one transaction (bind or lookup) with valid/ready;
// rsp_ returns exactly one result per request (status, found handle).
// A bind updates an existing binding or takes the lowest free slot;
// with no free slot it returns table full. A lookup returns the handle or
// a miss. A 4096-bit presence bitmap screens every access.
//
// Sequence: a request is accepted in idle; in the launch step the bitmap
// row read at accept screens the probe as it enters the slot chain; the
// probe then passes through the registered cells of the chain in order;
// the finish step loads the result into the output register. One request
// at a time: the next is accepted only after the finish step returns to idle.
//
// Reset: all slots are freed and the bitmap is cleared by a pass over its
// 128 rows, one row per cycle; req_ready stays low during the pass.
// Stall: a result waits in the output register while the next request is
// accepted and scanned; that request's result then holds in the finish
// step until the output register is free.
`default_nettype none

module key_binding_table #(
   parameter int TABLE_ENTRIES = 64,
   parameter int HANDLE_BITS   = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic                                      req_operation,
   input  logic [kbt_pkg::KEY_CODE_BITS-1:0]         req_key_code,
   input  logic [kbt_pkg::MOD_BITS-1:0]              req_modifier_bits,
   input  logic [kbt_pkg::HANDLE_FIELD_BITS-1:0]     req_new_handle,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic [kbt_pkg::STATUS_BITS-1:0]           rsp_status,
   output logic [kbt_pkg::HANDLE_FIELD_BITS-1:0]     rsp_found_handle
);
   import kbt_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_LAUNCH = 2'd1;
   localparam logic [1:0] S_SCAN   = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0]                   state_ff;
   logic [1:0]                   state_in;
   logic                         map_busy;
   logic [MAP_ROW_BITS-1:0]      map_rd_data;
   logic [MAP_ADDR_BITS-1:0]     map_rd_row;
   kbt_map_wr_type               map_wr;

   logic                         op_ff;
   logic [KEY_BITS-1:0]          key_ff;
   logic [HANDLE_BITS-1:0]       handle_ff;
   logic [HANDLE_BITS-1:0]       req_handle_ext;
   logic [MAP_ROW_BITS-1:0]      row_ff;
   logic                         filled_ff;
   logic [STATUS_BITS-1:0]       res_status_ff;
   logic [HANDLE_FIELD_BITS-1:0] res_found_ff;
   logic [HANDLE_FIELD_BITS-1:0] exit_found;

   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic [STATUS_BITS-1:0]       rsp_status_ff;
   logic [HANDLE_FIELD_BITS-1:0] rsp_found_ff;

   kbt_probe_type                probe_chain [TABLE_ENTRIES+1];
   logic [HANDLE_BITS-1:0]       lane_chain  [TABLE_ENTRIES+1];
   kbt_probe_type                exit_probe;
   logic                         req_fire;
   logic                         out_free;

   assign req_ready = (state_ff == S_IDLE) && !map_busy;
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Fit the handle field to the stored handle width and back
   generate
      if (HANDLE_BITS > HANDLE_FIELD_BITS) begin : g_wide
         assign req_handle_ext =
            {{(HANDLE_BITS - HANDLE_FIELD_BITS){1'b0}}, req_new_handle};
         assign exit_found = lane_chain[TABLE_ENTRIES][HANDLE_FIELD_BITS-1:0];
      end else if (HANDLE_BITS == HANDLE_FIELD_BITS) begin : g_same
         assign req_handle_ext = req_new_handle;
         assign exit_found     = lane_chain[TABLE_ENTRIES];
      end else begin : g_narrow
         assign req_handle_ext = req_new_handle[HANDLE_BITS-1:0];
         assign exit_found     =
            {{(HANDLE_FIELD_BITS - HANDLE_BITS){1'b0}}, lane_chain[TABLE_ENTRIES]};
      end
   endgenerate

   // Presence bitmap: the row is the upper seven bits of the key
   assign map_rd_row = {req_modifier_bits, req_key_code[KEY_CODE_BITS-1:MAP_SEL_BITS]};

   kbt_bitmap u_bitmap (
      .clock   (clock),
      .reset   (reset),
      .rd_row  (map_rd_row),
      .rd_data (map_rd_data),
      .wr      (map_wr),
      .busy    (map_busy)
   );

   // Set the key's bit in the row read at accept when a slot was filled
   always_comb begin
      map_wr      = '0;
      map_wr.row  = key_ff[KEY_BITS-1:MAP_SEL_BITS];
      map_wr.data = row_ff;
      map_wr.data[key_ff[MAP_SEL_BITS-1:0]] = 1'b1;
      map_wr.en   = (state_ff == S_FINISH) && out_free && filled_ff;
   end

   // Launch the probe into the first cell
   always_comb begin
      probe_chain[0]        = '0;
      probe_chain[0].active = (state_ff == S_LAUNCH);
      probe_chain[0].op     = op_ff;
      probe_chain[0].key    = key_ff;
      probe_chain[0].screen = map_rd_data[key_ff[MAP_SEL_BITS-1:0]];
   end
   assign lane_chain[0] = handle_ff;

   // Slot chain
   generate
      for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
         kbt_cell #(
            .HANDLE_BITS (HANDLE_BITS)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .probe_in   (probe_chain[i]),
            .handle_in  (lane_chain[i]),
            .probe_out  (probe_chain[i+1]),
            .handle_out (lane_chain[i+1])
         );
      end
   endgenerate

   assign exit_probe = probe_chain[TABLE_ENTRIES];

   // Sequence one transaction at a time
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_LAUNCH;
            end
         end
         S_LAUNCH: state_in = S_SCAN;
         S_SCAN: begin
            if (exit_probe.active) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Capture the request, the bitmap row and the scan outcome
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff     <= req_operation;
         key_ff    <= {req_modifier_bits, req_key_code};
         handle_ff <= req_handle_ext;
      end
      if (state_ff == S_LAUNCH) begin
         row_ff <= map_rd_data;
      end
      if ((state_ff == S_SCAN) && exit_probe.active) begin
         filled_ff    <= exit_probe.filled;
         res_found_ff <= '0;
         if (exit_probe.op == OP_BIND) begin
            res_status_ff <= exit_probe.done ? ST_OK : ST_FULL;
         end else begin
            res_status_ff <= exit_probe.done ? ST_OK : ST_MISS;
            if (exit_probe.done) begin
               res_found_ff <= exit_found;
            end
         end
      end
   end

   // Output register: load when free, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if ((state_ff == S_FINISH) && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_FINISH) && out_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_found_ff  <= res_found_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_found_handle = rsp_found_ff;

endmodule

`default_nettype wire
